/* rtl/sms_pkg.sv */
// Shared constants, types and helper functions of the spectrum statistics block.
package sms_pkg;

   localparam int BIN_WIDTH_W  = 24;
   localparam int FULL_SCALE_W = 32;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 1;
   localparam int PART_W       = 32;
   localparam int MAG_W        = 32;
   localparam int PEAK_W       = 33;
   localparam int ACC_W        = 64;
   localparam int SAMPLE_W     = 15;
   localparam int CENTROID_W   = 24;
   localparam int UNIT_W       = 65;
   localparam int STEP_W       = 5;

   localparam int MAX_BINS     = 65536;
   localparam int COUNT_W      = $clog2(MAX_BINS + 1);

   localparam logic [COUNT_W-1:0]      MAX_BINS_CNT   = COUNT_W'(MAX_BINS);
   localparam logic [MAG_W-1:0]        SAMPLE_MAX_MUL = MAG_W'(32767);
   localparam logic [CENTROID_W-1:0]   SAMPLE_SAT     = CENTROID_W'(32767);
   localparam logic [CENTROID_W-1:0]   CENTROID_SAT   = '1;

   localparam logic [BIN_WIDTH_W-1:0]  BIN_WIDTH_RST  = BIN_WIDTH_W'(256);
   localparam logic [FULL_SCALE_W-1:0] FULL_SCALE_RST = FULL_SCALE_W'(2000000);

   localparam logic [CSR_INDEX_W-1:0]  CSR_BIN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0]  CSR_FULL_SCALE = 1'b1;

   // sqrt digit count and divide step counts, loaded as last-step index
   localparam logic [STEP_W-1:0] SQRT_LAST  = STEP_W'(31);
   localparam logic [STEP_W-1:0] SCALE_LAST = STEP_W'(14);
   localparam logic [STEP_W-1:0] CENT_LAST  = STEP_W'(23);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_SQ_SUM,
      ST_SQRT,
      ST_SCALE_MUL,
      ST_SCALE_CHK,
      ST_SCALE_DIV,
      ST_AREA_MUL,
      ST_AREA_ACC,
      ST_WSUM_ACC,
      ST_CENT_CHK,
      ST_CENT_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [PART_W-1:0] bin_real;
      logic signed [PART_W-1:0] bin_imag;
      logic                     last_bin;
   } req_item_type;

   typedef struct packed {
      logic step_first;
      logic step_second;
      logic clear;
   } stats_ctl_type;

   typedef struct packed {
      logic [COUNT_W-1:0] index_count;
      logic [PEAK_W-1:0]  peak;
      logic [ACC_W-1:0]   area;
      logic [ACC_W-1:0]   area_integral;
      logic [ACC_W-1:0]   magnitude_sum;
      logic [ACC_W-1:0]   weighted_sum;
   } stats_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]   scaled_sample;
      logic                  frame_done;
      logic [COUNT_W-1:0]    bin_count;
      logic [ACC_W-1:0]      area_total;
      logic [ACC_W-1:0]      area_integral;
      logic [PEAK_W-1:0]     peak_magnitude;
      logic [CENTROID_W-1:0] centroid_q8;
   } result_type;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [ACC_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
   endfunction

   function automatic logic [PART_W-1:0] abs_part(input logic signed [PART_W-1:0] v);
      return v[PART_W-1] ? (~v + PART_W'(1)) : v;
   endfunction

endpackage

/* rtl/sms_channels.sv */
// Request and response channel interfaces of the spectrum statistics block.
interface sms_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sms_pkg::PART_W-1:0]     bin_real;
   logic signed [sms_pkg::PART_W-1:0]     bin_imag;
   logic                                  last_bin;

   modport source (output valid, bin_real, bin_imag, last_bin, input ready);
   modport sink   (input valid, bin_real, bin_imag, last_bin, output ready);
endinterface

interface sms_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [sms_pkg::SAMPLE_W-1:0]          scaled_sample;
   logic                                  frame_done;
   logic [sms_pkg::COUNT_W-1:0]           bin_count;
   logic [sms_pkg::ACC_W-1:0]             area_total;
   logic [sms_pkg::ACC_W-1:0]             area_integral;
   logic [sms_pkg::PEAK_W-1:0]            peak_magnitude;
   logic [sms_pkg::CENTROID_W-1:0]        centroid_q8;

   modport source (output valid, scaled_sample, frame_done, bin_count, area_total,
                   area_integral, peak_magnitude, centroid_q8, input ready);
   modport sink   (input valid, scaled_sample, frame_done, bin_count, area_total,
                   area_integral, peak_magnitude, centroid_q8, output ready);
endinterface

/* rtl/spectrum_magnitude_statistics_top.sv */
// Top level of the spectrum magnitude statistics block: config, core, output register.
//
// Usage: one complex FFT bin is offered per transfer on req_if (bin_real,
// bin_imag, last_bin). Every bin yields exactly one transfer on rsp_if with
// the scaled magnitude sample; on the closing bin of a frame (last_bin set,
// or the 65536th bin) frame_done is 1 and the frame summary fields carry the
// bin count, area, area integral, peak magnitude and Q16.8 centroid.
// A bin's result and the next bin can transfer on the same edge. The scaling divide
// is skipped when the sample saturates; a closing bin adds the centroid divide,
// skipped if the centroid is 0 or saturates. One compare-subtract unit runs 32
// square-root, up to 15 scaling and 24 centroid steps, beside one 32x32
// multiplier. One bin is in work at a time.
// The result is held in an output register, so a new bin is taken while the
// previous result waits; if the receiver stalls longer, the core holds its
// finished result and req_if.ready stays low.
// Registers (csr_*): index 0 bin width (Q16.8), index 1 full scale; write
// only while idle. Reset (synchronous) restores their defaults, clears the
// frame accumulators and empties the output register.
module spectrum_magnitude_statistics_top (
   input  logic                             clock,
   input  logic                             reset,
   sms_req_if.sink                          req_if,
   sms_rsp_if.source                        rsp_if,
   input  logic                             csr_write_enable,
   input  logic [sms_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sms_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   logic [sms_pkg::BIN_WIDTH_W-1:0]  bin_width_ff, bin_width_in;
   logic [sms_pkg::FULL_SCALE_W-1:0] full_scale_ff, full_scale_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sms_pkg::result_type              result_ff, result_in;

   sms_pkg::req_item_type            item;
   logic                             done_valid;
   logic                             done_ready;
   sms_pkg::result_type              done_result;

   assign item.bin_real = req_if.bin_real;
   assign item.bin_imag = req_if.bin_imag;
   assign item.last_bin = req_if.last_bin;

   sms_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_if.valid),
      .in_ready    (req_if.ready),
      .in_item     (item),
      .bin_width   (bin_width_ff),
      .full_scale  (full_scale_ff),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_result (done_result)
   );

   // configuration writes
   always_comb begin
      bin_width_in  = bin_width_ff;
      full_scale_in = full_scale_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            sms_pkg::CSR_BIN_WIDTH:
               bin_width_in = csr_write_data[sms_pkg::BIN_WIDTH_W-1:0];
            sms_pkg::CSR_FULL_SCALE:
               full_scale_in = csr_write_data[sms_pkg::FULL_SCALE_W-1:0];
            default: begin
               bin_width_in = bin_width_ff;
            end
         endcase
      end
   end

   // output register: loads when empty or drained in the same cycle
   assign done_ready = ~rsp_valid_ff | rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         result_in    = done_result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff  <= sms_pkg::BIN_WIDTH_RST;
         full_scale_ff <= sms_pkg::FULL_SCALE_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bin_width_ff  <= bin_width_in;
         full_scale_ff <= full_scale_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.scaled_sample  = result_ff.scaled_sample;
   assign rsp_if.frame_done     = result_ff.frame_done;
   assign rsp_if.bin_count      = result_ff.bin_count;
   assign rsp_if.area_total     = result_ff.area_total;
   assign rsp_if.area_integral  = result_ff.area_integral;
   assign rsp_if.peak_magnitude = result_ff.peak_magnitude;
   assign rsp_if.centroid_q8    = result_ff.centroid_q8;

endmodule

/* rtl/sms_cmpsub.sv */
// Shared compare-subtract unit used by the square root and both dividers.
module sms_cmpsub (
   input  logic [sms_pkg::UNIT_W-1:0] a,
   input  logic [sms_pkg::UNIT_W-1:0] b,
   output logic [sms_pkg::UNIT_W-1:0] diff,
   output logic                       ge
);

   logic [sms_pkg::UNIT_W:0] full_diff;

   assign full_diff = {1'b0, a} - {1'b0, b};
   assign diff      = full_diff[sms_pkg::UNIT_W-1:0];
   assign ge        = ~full_diff[sms_pkg::UNIT_W];

endmodule

/* rtl/sms_stats.sv */
// Frame accumulators: bin count, peak, area, area integral, magnitude sums.
module sms_stats (
   input  logic                          clock,
   input  logic                          reset,
   input  sms_pkg::stats_ctl_type        ctl,
   input  logic [sms_pkg::MAG_W-1:0]     mag,
   input  logic [sms_pkg::ACC_W-1:0]     prod,
   output sms_pkg::stats_type            st
);

   sms_pkg::stats_type st_ff;
   sms_pkg::stats_type st_in;

   always_comb begin
      st_in = st_ff;
      priority if (ctl.clear) begin
         st_in = '0;
      end else if (ctl.step_first) begin
         // prod holds mag * bin_width
         st_in.area          = sms_pkg::sat_add(st_ff.area, prod);
         st_in.magnitude_sum = sms_pkg::sat_add(st_ff.magnitude_sum,
                                                sms_pkg::ACC_W'(mag));
         st_in.index_count   = st_ff.index_count + sms_pkg::COUNT_W'(1);
         if (sms_pkg::PEAK_W'(mag) > st_ff.peak) begin
            st_in.peak = sms_pkg::PEAK_W'(mag);
         end
      end else if (ctl.step_second) begin
         // prod holds mag * bin index; area already includes this bin
         st_in.weighted_sum  = sms_pkg::sat_add(st_ff.weighted_sum, prod);
         st_in.area_integral = sms_pkg::sat_add(st_ff.area_integral, st_ff.area);
      end else begin
         st_in = st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   assign st = st_ff;

endmodule

/* rtl/sms_core.sv */
// Sequencer and datapath: magnitude and scaled sample per bin, centroid per frame.
module sms_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  sms_pkg::req_item_type             in_item,
   input  logic [sms_pkg::BIN_WIDTH_W-1:0]   bin_width,
   input  logic [sms_pkg::FULL_SCALE_W-1:0]  full_scale,
   output logic                              done_valid,
   input  logic                              done_ready,
   output sms_pkg::result_type               done_result
);

   sms_pkg::state_type                 state_ff, state_in;
   logic [sms_pkg::PART_W-1:0]         re_ff, re_in;
   logic [sms_pkg::PART_W-1:0]         im_ff, im_in;
   logic                               last_ff, last_in;
   logic [sms_pkg::ACC_W-1:0]          x_ff, x_in;
   logic [sms_pkg::ACC_W-1:0]          rem_ff, rem_in;
   logic [sms_pkg::MAG_W-1:0]          root_ff, root_in;
   logic [sms_pkg::CENTROID_W-1:0]     q_ff, q_in;
   logic [sms_pkg::STEP_W-1:0]         cnt_ff, cnt_in;
   logic [sms_pkg::ACC_W-1:0]          mul_ff, mul_in;
   logic [sms_pkg::SAMPLE_W-1:0]       scaled_ff, scaled_in;
   logic                               frame_end_ff, frame_end_in;

   logic [sms_pkg::MAG_W-1:0]          mul_a, mul_b;
   logic [sms_pkg::ACC_W-1:0]          prod_w;
   logic [sms_pkg::UNIT_W-1:0]         unit_a, unit_b, unit_diff;
   logic                               unit_ge;
   logic                               frame_end_now;
   logic                               mag_sum_zero;
   sms_pkg::stats_ctl_type             stats_ctl;
   sms_pkg::stats_type                 st;

   sms_cmpsub u_cmpsub (
      .a    (unit_a),
      .b    (unit_b),
      .diff (unit_diff),
      .ge   (unit_ge)
   );

   sms_stats u_stats (
      .clock (clock),
      .reset (reset),
      .ctl   (stats_ctl),
      .mag   (root_ff),
      .prod  (mul_ff),
      .st    (st)
   );

   // single shared 32x32 multiplier, registered in mul_ff
   assign prod_w = sms_pkg::ACC_W'(mul_a) * sms_pkg::ACC_W'(mul_b);

   assign frame_end_now = last_ff || (st.index_count == sms_pkg::MAX_BINS_CNT);
   assign mag_sum_zero  = (st.magnitude_sum == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sms_pkg::ST_IDLE:      if (in_valid) state_in = sms_pkg::ST_SQ_RE;
         sms_pkg::ST_SQ_RE:     state_in = sms_pkg::ST_SQ_IM;
         sms_pkg::ST_SQ_IM:     state_in = sms_pkg::ST_SQ_SUM;
         sms_pkg::ST_SQ_SUM:    state_in = sms_pkg::ST_SQRT;
         sms_pkg::ST_SQRT:      if (cnt_ff == '0) state_in = sms_pkg::ST_SCALE_MUL;
         sms_pkg::ST_SCALE_MUL: state_in = sms_pkg::ST_SCALE_CHK;
         sms_pkg::ST_SCALE_CHK: state_in = unit_ge ? sms_pkg::ST_AREA_MUL
                                                   : sms_pkg::ST_SCALE_DIV;
         sms_pkg::ST_SCALE_DIV: if (cnt_ff == '0) state_in = sms_pkg::ST_AREA_MUL;
         sms_pkg::ST_AREA_MUL:  state_in = sms_pkg::ST_AREA_ACC;
         sms_pkg::ST_AREA_ACC:  state_in = sms_pkg::ST_WSUM_ACC;
         sms_pkg::ST_WSUM_ACC:  state_in = frame_end_now ? sms_pkg::ST_CENT_CHK
                                                         : sms_pkg::ST_DONE;
         sms_pkg::ST_CENT_CHK:  state_in = (mag_sum_zero || unit_ge) ? sms_pkg::ST_DONE
                                                                     : sms_pkg::ST_CENT_DIV;
         sms_pkg::ST_CENT_DIV:  if (cnt_ff == '0) state_in = sms_pkg::ST_DONE;
         sms_pkg::ST_DONE:      if (done_ready) state_in = sms_pkg::ST_IDLE;
         default:               state_in = sms_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      re_in        = re_ff;
      im_in        = im_ff;
      last_in      = last_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      mul_in       = mul_ff;
      scaled_in    = scaled_ff;
      frame_end_in = frame_end_ff;
      mul_a        = '0;
      mul_b        = '0;
      unit_a       = '0;
      unit_b       = '0;
      stats_ctl    = '0;
      in_ready     = 1'b0;
      done_valid   = 1'b0;
      done_result  = '0;

      unique case (state_ff)
         sms_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               re_in   = sms_pkg::abs_part(in_item.bin_real);
               im_in   = sms_pkg::abs_part(in_item.bin_imag);
               last_in = in_item.last_bin;
            end
         end
         sms_pkg::ST_SQ_RE: begin
            mul_a  = re_ff;
            mul_b  = re_ff;
            mul_in = prod_w;
         end
         sms_pkg::ST_SQ_IM: begin
            mul_a  = im_ff;
            mul_b  = im_ff;
            mul_in = prod_w;
            x_in   = mul_ff;
         end
         sms_pkg::ST_SQ_SUM: begin
            // at most 2^63, no carry out
            x_in    = x_ff + mul_ff;
            rem_in  = '0;
            root_in = '0;
            cnt_in  = sms_pkg::SQRT_LAST;
         end
         sms_pkg::ST_SQRT: begin
            // one root digit: trial (root<<2)|1 against (rem<<2)|next pair
            unit_a  = sms_pkg::UNIT_W'({rem_ff[sms_pkg::ACC_W-3:0],
                                        x_ff[sms_pkg::ACC_W-1 -: 2]});
            unit_b  = sms_pkg::UNIT_W'({root_ff, 2'b01});
            rem_in  = unit_ge ? unit_diff[sms_pkg::ACC_W-1:0] : unit_a[sms_pkg::ACC_W-1:0];
            root_in = {root_ff[sms_pkg::MAG_W-2:0], unit_ge};
            x_in    = x_ff << 2;
            cnt_in  = cnt_ff - sms_pkg::STEP_W'(1);
         end
         sms_pkg::ST_SCALE_MUL: begin
            mul_a  = root_ff;
            mul_b  = sms_pkg::SAMPLE_MAX_MUL;
            mul_in = prod_w;
         end
         sms_pkg::ST_SCALE_CHK: begin
            // quotient >= 32768 (or zero full scale) when N>>15 >= full_scale
            unit_a = sms_pkg::UNIT_W'(mul_ff[sms_pkg::ACC_W-1:15]);
            unit_b = sms_pkg::UNIT_W'(full_scale);
            if (unit_ge) begin
               q_in = sms_pkg::SAMPLE_SAT;
            end else begin
               rem_in = unit_a[sms_pkg::ACC_W-1:0];
               x_in   = mul_ff << (sms_pkg::ACC_W - 15);
               q_in   = '0;
               cnt_in = sms_pkg::SCALE_LAST;
            end
         end
         sms_pkg::ST_SCALE_DIV: begin
            unit_a = {rem_ff, x_ff[sms_pkg::ACC_W-1]};
            unit_b = sms_pkg::UNIT_W'(full_scale);
            rem_in = unit_ge ? unit_diff[sms_pkg::ACC_W-1:0] : unit_a[sms_pkg::ACC_W-1:0];
            q_in   = {q_ff[sms_pkg::CENTROID_W-2:0], unit_ge};
            x_in   = x_ff << 1;
            cnt_in = cnt_ff - sms_pkg::STEP_W'(1);
         end
         sms_pkg::ST_AREA_MUL: begin
            scaled_in = q_ff[sms_pkg::SAMPLE_W-1:0];
            mul_a     = root_ff;
            mul_b     = sms_pkg::MAG_W'(bin_width);
            mul_in    = prod_w;
         end
         sms_pkg::ST_AREA_ACC: begin
            stats_ctl.step_first = 1'b1;
            mul_a  = root_ff;
            mul_b  = sms_pkg::MAG_W'(st.index_count);
            mul_in = prod_w;
         end
         sms_pkg::ST_WSUM_ACC: begin
            stats_ctl.step_second = 1'b1;
            frame_end_in = frame_end_now;
         end
         sms_pkg::ST_CENT_CHK: begin
            // integer part above 16 bits saturates
            unit_a = sms_pkg::UNIT_W'(st.weighted_sum[sms_pkg::ACC_W-1:16]);
            unit_b = sms_pkg::UNIT_W'(st.magnitude_sum);
            if (mag_sum_zero) begin
               q_in = '0;
            end else if (unit_ge) begin
               q_in = sms_pkg::CENTROID_SAT;
            end else begin
               rem_in = unit_a[sms_pkg::ACC_W-1:0];
               x_in   = st.weighted_sum << (sms_pkg::ACC_W - 16);
               q_in   = '0;
               cnt_in = sms_pkg::CENT_LAST;
            end
         end
         sms_pkg::ST_CENT_DIV: begin
            unit_a = {rem_ff, x_ff[sms_pkg::ACC_W-1]};
            unit_b = sms_pkg::UNIT_W'(st.magnitude_sum);
            rem_in = unit_ge ? unit_diff[sms_pkg::ACC_W-1:0] : unit_a[sms_pkg::ACC_W-1:0];
            q_in   = {q_ff[sms_pkg::CENTROID_W-2:0], unit_ge};
            x_in   = x_ff << 1;
            cnt_in = cnt_ff - sms_pkg::STEP_W'(1);
         end
         sms_pkg::ST_DONE: begin
            done_valid                = 1'b1;
            done_result.scaled_sample = scaled_ff;
            done_result.frame_done    = frame_end_ff;
            if (frame_end_ff) begin
               done_result.bin_count      = st.index_count;
               done_result.area_total     = st.area;
               done_result.area_integral  = st.area_integral;
               done_result.peak_magnitude = st.peak;
               done_result.centroid_q8    = q_ff;
            end
            stats_ctl.clear = done_ready && frame_end_ff;
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      re_ff        <= re_in;
      im_ff        <= im_in;
      last_ff      <= last_in;
      x_ff         <= x_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      q_ff         <= q_in;
      cnt_ff       <= cnt_in;
      mul_ff       <= mul_in;
      scaled_ff    <= scaled_in;
      frame_end_ff <= frame_end_in;
   end

endmodule

/* bench/spectrum_statistics_checker.sv */
// Channel monitor that predicts each bin result of the spectrum statistics block and compares it.
`timescale 1ns / 100ps
module spectrum_statistics_checker (
   input  logic                             clock,
   input  logic                             reset,
   sms_req_if                               req_mon,
   sms_rsp_if                               rsp_mon,
   input  logic                             csr_write_enable,
   input  logic [sms_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sms_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output int                               mismatch_count,
   output int                               owed_count,
   output int                               results_seen,
   output int                               frames_seen
);
   import sms_pkg::*;

   localparam logic [63:0] SAMPLE_CEIL = 64'd32767;
   localparam int          REPORT_MAX  = 10;

   // register copies
   logic [BIN_WIDTH_W-1:0]  width_q8;
   logic [FULL_SCALE_W-1:0] scale_ref;

   // frame accumulators
   int                      bins_taken;
   logic [PEAK_W-1:0]       peak_seen;
   logic [ACC_W-1:0]        area_run;
   logic [ACC_W-1:0]        area_sum_run;
   logic [ACC_W-1:0]        mag_total;
   logic [ACC_W-1:0]        idx_weighted;

   result_type              owed_results[$];

   function automatic logic [ACC_W-1:0] clamp_add(input logic [ACC_W-1:0] a,
                                                  input logic [ACC_W-1:0] b);
      logic [ACC_W-1:0] s;
      s = a + b;
      return (s < a) ? '1 : s;
   endfunction

   // bit-by-bit floor square root, MSB first
   function automatic logic [MAG_W-1:0] floor_root(input logic [63:0] power);
      logic [MAG_W-1:0] root;
      logic [MAG_W-1:0] trial;
      logic [63:0]      wide;
      root = '0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
         trial = root;
         trial[b] = 1'b1;
         wide = trial;
         if (wide * wide <= power) root = trial;
      end
      return root;
   endfunction

   // integer part by division, then 8 fraction bits by restoring steps
   function automatic logic [CENTROID_W-1:0] q8_centroid(input logic [ACC_W-1:0] num,
                                                         input logic [ACC_W-1:0] den);
      logic [ACC_W-1:0] quo;
      logic [ACC_W-1:0] rem;
      logic             carry;
      if (den == '0) return '0;
      quo = num / den;
      rem = num % den;
      if (quo > 64'hFFFF) return '1;
      for (int k = 0; k < 8; k++) begin
         carry = rem[ACC_W-1];
         rem = rem << 1;
         if (carry || rem >= den) begin
            rem = rem - den;
            quo = {quo[ACC_W-2:0], 1'b1};
         end else begin
            quo = {quo[ACC_W-2:0], 1'b0};
         end
      end
      return quo[CENTROID_W-1:0];
   endfunction

   function automatic void clear_frame();
      bins_taken   = 0;
      peak_seen    = '0;
      area_run     = '0;
      area_sum_run = '0;
      mag_total    = '0;
      idx_weighted = '0;
   endfunction

   function automatic result_type predict_bin(input logic signed [PART_W-1:0] re,
                                              input logic signed [PART_W-1:0] im,
                                              input logic                     last);
      longint      sr;
      longint      si;
      logic [63:0] re_abs;
      logic [63:0] im_abs;
      logic [63:0] mag;
      logic [63:0] quo;
      logic        closing;
      result_type  res;
      sr = re;
      si = im;
      re_abs = (sr < 0) ? -sr : sr;
      im_abs = (si < 0) ? -si : si;
      mag = floor_root(re_abs * re_abs + im_abs * im_abs);

      if (scale_ref == '0) begin
         quo = SAMPLE_CEIL;
      end else begin
         quo = (mag * SAMPLE_CEIL) / 64'(scale_ref);
         if (quo > SAMPLE_CEIL) quo = SAMPLE_CEIL;
      end

      if (mag > 64'(peak_seen)) peak_seen = mag[PEAK_W-1:0];
      area_run     = clamp_add(area_run, mag * 64'(width_q8));
      area_sum_run = clamp_add(area_sum_run, area_run);
      mag_total    = clamp_add(mag_total, mag);
      idx_weighted = clamp_add(idx_weighted, mag * 64'(bins_taken));
      bins_taken++;
      // a full frame closes on its own
      closing = last || (bins_taken >= MAX_BINS);

      res = '0;
      res.scaled_sample = quo[SAMPLE_W-1:0];
      if (closing) begin
         res.frame_done     = 1'b1;
         res.bin_count      = COUNT_W'(bins_taken);
         res.area_total     = area_run;
         res.area_integral  = area_sum_run;
         res.peak_magnitude = peak_seen;
         res.centroid_q8    = q8_centroid(idx_weighted, mag_total);
         clear_frame();
      end
      return res;
   endfunction

   task automatic check_field(input string label, input logic [ACC_W-1:0] want,
                              input logic [ACC_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("result %0d: %s expected %0d got %0d", results_seen, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         width_q8  = BIN_WIDTH_RST;
         scale_ref = FULL_SCALE_RST;
         clear_frame();
         owed_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("result %0d: transfer with no bin outstanding", results_seen);
            end else begin
               want = owed_results.pop_front();
               check_field("scaled_sample", want.scaled_sample, rsp_mon.scaled_sample);
               check_field("frame_done", want.frame_done, rsp_mon.frame_done);
               check_field("bin_count", want.bin_count, rsp_mon.bin_count);
               check_field("area_total", want.area_total, rsp_mon.area_total);
               check_field("area_integral", want.area_integral, rsp_mon.area_integral);
               check_field("peak_magnitude", want.peak_magnitude, rsp_mon.peak_magnitude);
               check_field("centroid_q8", want.centroid_q8, rsp_mon.centroid_q8);
            end
            results_seen++;
         end
         if (req_mon.valid && req_mon.ready) begin
            want = predict_bin(req_mon.bin_real, req_mon.bin_imag, req_mon.last_bin);
            owed_results.push_back(want);
            if (want.frame_done) frames_seen++;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BIN_WIDTH:  width_q8  = csr_write_data[BIN_WIDTH_W-1:0];
               CSR_FULL_SCALE: scale_ref = csr_write_data[FULL_SCALE_W-1:0];
               default: ;
            endcase
         end
      end
      owed_count = owed_results.size();
   end

endmodule

/* bench/spectrum_magnitude_statistics_top_tb.sv */
// Stimulus, register setup, watchdog and verdict for the spectrum magnitude statistics block.
`timescale 1ns / 100ps
module spectrum_magnitude_statistics_top_tb;
   import sms_pkg::*;

   // Run shape: a short directed frame set, then random phases, each with its own
   // register setting; one phase is a long frame of near-full-scale bins at the
   // widest bin width so the area and area-integral accumulators saturate.
   localparam int PHASES         = 8;
   localparam int HEAVY_PHASE    = 2;
   localparam int PHASE_BINS     = 95;
   localparam int HEAVY_BINS     = 450;
   // no transfer for this long means the block is stuck; the limit covers a closing
   // bin's centroid divide plus sender gaps and receiver stalls
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 100;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_write_enable;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;

   int                      mismatch_count;
   int                      owed_count;
   int                      results_seen;
   int                      frames_seen;

   bit                      idling_allowed;
   int                      stall_left;
   int                      idle_cycles;
   int                      setting_count;

   sms_req_if req_ch ();
   sms_rsp_if rsp_ch ();

   spectrum_magnitude_statistics_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   spectrum_statistics_checker bin_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .owed_count       (owed_count),
      .results_seen     (results_seen),
      .frames_seen      (frames_seen)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: stalls in bursts while idling is allowed,
   // otherwise always ready. Changes only on the falling edge.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else if (idling_allowed && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = $urandom_range(1, 14) - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog: counts cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset === 1'b1 || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results still owed",
                  idle_cycles, owed_count);
         $display("spectrum_magnitude_statistics_top_tb NOT OK");
         $finish;
      end
   end

   // Offers one bin, optionally after a sender gap, and returns at the rising
   // edge where it transfers. Valid stays high afterwards until the next call
   // or drop_request decides at the following falling edge.
   task automatic send_bin(input logic signed [PART_W-1:0] re,
                           input logic signed [PART_W-1:0] im,
                           input logic                     last);
      int gap;
      gap = (idling_allowed && $urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.bin_real <= re;
      req_ch.bin_imag <= im;
      req_ch.last_bin <= last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic drop_request();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // Every bin yields a result, so the block is idle once nothing is owed.
   // Checked after a falling edge so the checker has seen the last transfer.
   task automatic drain();
      drop_request();
      wait (owed_count == 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0]   width_word,
                                input logic [FULL_SCALE_W-1:0] scale);
      drain();
      write_reg(CSR_BIN_WIDTH, width_word);
      write_reg(CSR_FULL_SCALE, scale);
      setting_count++;
   endtask

   // Spread over all magnitudes: zero, both extremes, full random, and
   // arithmetic shifts of a random word so small values show up often.
   function automatic logic signed [PART_W-1:0] random_part();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 32'sh8000_0000;
         2:       return 32'sh7FFF_FFFF;
         3:       return $signed($urandom);
         default: return $signed($urandom) >>> $urandom_range(0, 31);
      endcase
   endfunction

   // magnitude at least 2^31 - 2^28, either sign
   function automatic logic signed [PART_W-1:0] heavy_part();
      logic signed [PART_W-1:0] v;
      v = {4'b1000, 28'($urandom)};
      if ($urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   function automatic logic [FULL_SCALE_W-1:0] random_scale();
      case ($urandom_range(0, 5))
         0:       return FULL_SCALE_W'(1);
         1:       return '1;
         2:       return FULL_SCALE_RST;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // upper data bits are junk on purpose; the register keeps only 24
   function automatic logic [CSR_DATA_W-1:0] random_width_word();
      logic [BIN_WIDTH_W-1:0] w;
      case ($urandom_range(0, 5))
         0:       w = BIN_WIDTH_W'(1);
         1:       w = '1;
         2:       w = BIN_WIDTH_RST;
         default: w = BIN_WIDTH_W'($urandom >> $urandom_range(8, 31));
      endcase
      return {8'($urandom), w};
   endfunction

   task automatic send_frame(input int len, input bit heavy);
      for (int k = 0; k < len; k++) begin
         if (heavy)
            send_bin(heavy_part(), heavy_part(), k == len - 1);
         else
            send_bin(random_part(), random_part(), k == len - 1);
      end
   endtask

   initial begin
      int sent;
      int len;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.bin_real  = '0;
      req_ch.bin_imag  = '0;
      req_ch.last_bin  = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_BIN_WIDTH;
      csr_write_data   = '0;
      idling_allowed   = 1'b1;
      stall_left       = 0;
      setting_count    = 1;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed, reset setting (bin width 1.0 Hz, full scale 2000000) ---
      send_bin(32'sh0000_0000, 32'sh0000_0000, 1'b0);   // zero magnitude
      send_bin(32'sh7FFF_FFFF, 32'sh0000_0000, 1'b0);   // positive extreme
      send_bin(32'sh8000_0000, 32'sh8000_0000, 1'b0);   // largest magnitude
      send_bin(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
      send_bin(-32'sd3, 32'sd4, 1'b0);
      send_bin(32'sd1000, -32'sd1000, 1'b0);             // sample well below full scale
      send_bin(32'sd0, -32'sd2000000, 1'b1);             // exactly full scale, closes frame
      send_bin(32'sh0000_0000, 32'sh0000_0000, 1'b1);   // zero-magnitude frame: centroid 0
      send_bin(-32'sd1, -32'sd1, 1'b1);                  // one-bin frame

      // widest bin width, junk in the upper data bits, smallest nonzero full scale
      apply_setting(32'hFFFF_FFFF, FULL_SCALE_W'(1));
      send_bin(32'sh8000_0000, 32'sh8000_0000, 1'b0);
      send_bin(32'sd5, 32'sd0, 1'b0);
      send_bin(32'sd7, 32'sd7, 1'b1);

      // zero full scale saturates every sample, even a zero magnitude
      apply_setting(32'hFFFF_FFFF, '0);
      send_bin(32'sd0, 32'sd0, 1'b0);
      send_bin(32'sd12, 32'sd5, 1'b1);

      // narrowest nonzero bin width, largest full scale
      apply_setting(32'h0000_0001, '1);
      send_bin(32'sh8000_0000, 32'sh8000_0000, 1'b0);
      send_bin(32'sd100, 32'sd0, 1'b1);

      // --- random phases; the last one runs without idling on either side ---
      for (int phase = 0; phase < PHASES; phase++) begin
         idling_allowed = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
         if (phase == HEAVY_PHASE) begin
            // one long loud frame: area integral saturates early, area near the end
            apply_setting({8'($urandom), 24'hFF_FFFF}, random_scale());
            send_frame(HEAVY_BINS, 1'b1);
         end else begin
            apply_setting(random_width_word(), random_scale());
            sent = 0;
            while (sent < PHASE_BINS) begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120)
                                                 : $urandom_range(1, 24);
               send_frame(len, 1'b0);
               sent += len;
            end
         end
      end

      // let everything drain, then give stray results time to show up
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d bins in %0d closed frames over %0d register settings",
               results_seen, frames_seen, setting_count);
      $display("%0d mismatches, %0d results still owed", mismatch_count, owed_count);
      if (mismatch_count == 0 && owed_count == 0) begin
         $display("spectrum_magnitude_statistics_top_tb OK");
      end else begin
         $display("spectrum_magnitude_statistics_top_tb NOT OK");
      end
      $finish;
   end

endmodule
